/* hdl/tkk_pkg.sv */
// Shared widths, register codes and control types for the top-k score keeper.
package tkk_pkg;

    localparam int SP_W       = 12;
    localparam int LVL_W      = 3;
    localparam int RULE_W     = 4;
    localparam int LABEL_W    = 8;
    localparam int RANK_W     = 3;
    localparam int TOPK_W     = 4;
    localparam int LC_W       = 4;
    localparam int CC_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    // superpixel * level_count + level always fits in 16 bits
    localparam int RAW_W      = 16;
    // headroom bits of the top-k sum over one score
    localparam int SUM_EXTRA  = 3;

    localparam logic [TOPK_W-1:0] TOP_K_RESET       = 4'd3;
    localparam logic [LC_W-1:0]   LEVEL_COUNT_RESET = 4'd1;
    localparam logic [CC_W-1:0]   CLASS_COUNT_RESET = 9'd2;

    // rule that starts a fresh pass and always overwrites the stored best
    localparam logic [RULE_W-1:0] FRESH_RULE = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP_K       = 2'd0,
        REG_LEVEL_COUNT = 2'd1,
        REG_CLASS_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        MODE_SCORE = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_RANKED = 1'b0,
        KIND_QUERY  = 1'b1
    } kind_t;

    typedef struct packed {
        logic step;   // a class score is inserted this cycle
        logic clear;  // the group completes: reload the empty list
    } cell_ctl_t;

endpackage

/* hdl/tkk_cell.sv */
// One rank slot of the sorted top-k chain.
module tkk_cell
    import tkk_pkg::*;
#(
    parameter int SCORE_BITS = 16,
    parameter int KW         = 4,
    parameter int IDX        = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_ctl_t                    ctl,
    input  logic [KW-1:0]                k_eff,
    input  logic [KW-1:0]                filled,
    input  logic signed [SCORE_BITS-1:0] new_score,
    input  logic [LABEL_W-1:0]           new_label,
    input  logic                         left_ge,
    input  logic signed [SCORE_BITS-1:0] left_score,
    input  logic [LABEL_W-1:0]           left_label,
    output logic                         ge_out,
    output logic signed [SCORE_BITS-1:0] score_out,
    output logic [LABEL_W-1:0]           label_out,
    output logic signed [SCORE_BITS-1:0] upd_score,
    output logic [LABEL_W-1:0]           upd_label
);

    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic [KW-1:0] MY_IDX = KW'(IDX);

    logic signed [SCORE_BITS-1:0] score_reg;
    logic [LABEL_W-1:0]           label_reg;

    // slot keeps its place when it is filled and not below the new score (ties stay)
    assign ge_out    = (MY_IDX < filled) && (score_reg >= new_score);
    assign score_out = score_reg;
    assign label_out = label_reg;

    always_comb begin
        upd_score = score_reg;
        upd_label = label_reg;
        if (ctl.step && (MY_IDX < k_eff) && !ge_out) begin
            if (left_ge) begin
                upd_score = new_score;
                upd_label = new_label;
            end else if (MY_IDX <= filled) begin
                upd_score = left_score;
                upd_label = left_label;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg <= SCORE_MIN;
            label_reg <= '0;
        end else if (ctl.step) begin
            score_reg <= ctl.clear ? SCORE_MIN : upd_score;
            label_reg <= ctl.clear ? '0 : upd_label;
        end
    end

endmodule

/* hdl/tkk_sum.sv */
// Two-stage registered adder tree with saturation for the top-k sum.
module tkk_sum
    import tkk_pkg::*;
#(
    parameter int SCORE_BITS = 16,
    parameter int MAX_K      = 8,
    parameter int KW         = 4,
    parameter int SUM_BITS   = 19
) (
    input  logic                         aclk,
    input  logic                         adv_first,
    input  logic                         adv_second,
    input  logic [KW-1:0]                n,
    input  logic signed [SCORE_BITS-1:0] scores [MAX_K],
    output logic signed [SUM_BITS-1:0]   sum_out
);

    localparam int Group = 4;
    localparam int NGRP  = (MAX_K + Group - 1) / Group;
    localparam int PW    = SCORE_BITS + SUM_EXTRA;
    localparam int ACC_W = SUM_BITS + KW;
    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

    logic signed [PW-1:0]       part      [NGRP];
    logic signed [PW-1:0]       part_reg  [NGRP];
    logic signed [ACC_W-1:0]    total;
    logic signed [SUM_BITS-1:0] sat;
    logic signed [SUM_BITS-1:0] sum_reg;

    // first level: groups of four ranks, ranks at or past n are dropped
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            part[g] = '0;
        end
        for (int j = 0; j < MAX_K; j++) begin
            if (KW'(j) < n) begin
                part[j / Group] = part[j / Group] + PW'(scores[j]);
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NGRP; g++) begin
            total = total + ACC_W'(part_reg[g]);
        end
        if (total > SMAX) begin
            sat = SUM_BITS'(SMAX);
        end else if (total < SMIN) begin
            sat = SUM_BITS'(SMIN);
        end else begin
            sat = SUM_BITS'(total);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_first) begin
            for (int g = 0; g < NGRP; g++) begin
                part_reg[g] <= part[g];
            end
        end
        if (adv_second) begin
            sum_reg <= sat;
        end
    end

    assign sum_out = sum_reg;

endmodule

/* hdl/top_k_score_sum_best_keeper_unit.sv */
// Top level: top-k class score chain, sum pipeline, per-entry best store, result stage.
// Result path: the completing transaction is registered through stages A, Q, B, C;
//   the first result of a finished group or a query answer comes from stage C.
// Input: one transaction per cycle while s_ready is high; a finished group holds
//   the output stage until its n results (n = ranks emitted, <= MAX_K) are taken.
// Reset (aresetn low, synchronous): registers back to their defaults, rank chain
//   emptied, all pipeline stages empty. The best-sum store is not initialized.
module top_k_score_sum_best_keeper_unit
    import tkk_pkg::*;
#(
    parameter int MAX_K       = 8,
    parameter int ENTRY_COUNT = 4096,
    parameter int MAX_CLASSES = 256,
    parameter int SCORE_BITS  = 16,
    localparam int SUM_BITS   = SCORE_BITS + SUM_EXTRA
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [SP_W-1:0]              s_superpixel,
    input  logic [LVL_W-1:0]             s_level,
    input  logic [RULE_W-1:0]            s_rule,
    input  logic signed [SCORE_BITS-1:0] s_score,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [RANK_W-1:0]            m_rank,
    output logic [LABEL_W-1:0]           m_label,
    output logic signed [SCORE_BITS-1:0] m_value,
    output logic signed [SUM_BITS-1:0]   m_top_sum,
    output logic                         m_updated,
    output logic [RULE_W-1:0]            m_best_rule,
    output logic                         m_last
);

    localparam int KW   = $clog2(MAX_K + 1);
    localparam int RI_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW   = $clog2(MAX_CLASSES + 1);
    localparam int EW   = $clog2(ENTRY_COUNT);
    localparam int MW   = SUM_BITS + RULE_W + LABEL_W + SCORE_BITS;
    localparam int PRW  = 2 * RAW_W + 1;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    // entry index modulo ENTRY_COUNT: exact reciprocal multiply for 16-bit dividends
    localparam int SHIFT = RAW_W + EW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(ENTRY_COUNT) - 64'd1) / 64'(ENTRY_COUNT);
    localparam logic [RAW_W:0] RECIP   = RECIP64[RAW_W:0];
    localparam logic [RAW_W:0] E_CONST = (RAW_W + 1)'(ENTRY_COUNT);

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [TOPK_W-1:0] top_k_reg;
    logic [LC_W-1:0]   level_count_reg;
    logic [CC_W-1:0]   class_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_reg       <= TOP_K_RESET;
            level_count_reg <= LEVEL_COUNT_RESET;
            class_count_reg <= CLASS_COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOP_K:       top_k_reg       <= cfg_data[TOPK_W-1:0];
                REG_LEVEL_COUNT: level_count_reg <= cfg_data[LC_W-1:0];
                REG_CLASS_COUNT: class_count_reg <= cfg_data[CC_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // Clamped working values
    logic [KW-1:0]   k_eff;
    logic [CW-1:0]   cc_eff;
    logic [LC_W-1:0] lc_eff;

    always_comb begin
        if (top_k_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(top_k_reg) > MAX_K) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(top_k_reg);
        end

        if (class_count_reg == '0) begin
            cc_eff = CW'(1);
        end else if (int'(class_count_reg) > MAX_CLASSES) begin
            cc_eff = CW'(MAX_CLASSES);
        end else begin
            cc_eff = CW'(class_count_reg);
        end

        lc_eff = (level_count_reg == '0) ? LC_W'(1) : level_count_reg;
    end

    //------------------------------------------------------------------
    // Pipeline handshake: A (snapshot), Q (quotient), B (store), C (emit)
    //------------------------------------------------------------------
    logic a_valid_reg, q_valid_reg, b_valid_reg, c_valid_reg;
    logic a_valid_next, q_valid_next, b_valid_next, c_valid_next;
    logic a_adv, q_adv, b_adv;
    logic a_free, q_free, b_free, c_free;
    logic acc, a_load, is_query;

    assign c_free = !c_valid_reg || (m_ready && m_last);
    assign b_adv  = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || c_free;
    assign q_adv  = q_valid_reg && b_free;
    assign q_free = !q_valid_reg || b_free;
    assign a_adv  = a_valid_reg && q_free;
    assign a_free = !a_valid_reg || q_free;

    assign s_ready  = a_free;
    assign acc      = s_valid && s_ready;
    assign is_query = (mode_t'(s_mode) == MODE_QUERY);

    //------------------------------------------------------------------
    // Class counter and the rank chain
    //------------------------------------------------------------------
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                done;
    logic [KW-1:0]       filled;
    logic [KW-1:0]       n_done;
    logic [LABEL_W-1:0]  new_label;
    cell_ctl_t           cell_ctl;

    assign cnt_next  = cnt_reg + CW'(1);
    assign done      = (cnt_next >= cc_eff);
    assign filled    = (int'(cnt_reg) < int'(k_eff)) ? KW'(cnt_reg) : k_eff;
    assign n_done    = (int'(cnt_next) < int'(k_eff)) ? KW'(cnt_next) : k_eff;
    assign new_label = LABEL_W'(cnt_reg);

    assign cell_ctl.step  = acc && !is_query;
    assign cell_ctl.clear = acc && !is_query && done;
    assign a_load         = acc && (is_query || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cell_ctl.step) begin
            cnt_reg <= done ? '0 : cnt_next;
        end
    end

    logic                         cell_ge      [MAX_K];
    logic signed [SCORE_BITS-1:0] cell_score   [MAX_K];
    logic [LABEL_W-1:0]           cell_label   [MAX_K];
    logic signed [SCORE_BITS-1:0] cell_upd_scr [MAX_K];
    logic [LABEL_W-1:0]           cell_upd_lab [MAX_K];
    logic                         left_ge      [MAX_K];
    logic signed [SCORE_BITS-1:0] left_score   [MAX_K];
    logic [LABEL_W-1:0]           left_label   [MAX_K];

    for (genvar j = 0; j < MAX_K; j++) begin : g_cell
        if (j == 0) begin : g_head
            // nothing ranks above slot 0
            assign left_ge[j]    = 1'b1;
            assign left_score[j] = SCORE_MIN;
            assign left_label[j] = '0;
        end else begin : g_link
            assign left_ge[j]    = cell_ge[j-1];
            assign left_score[j] = cell_score[j-1];
            assign left_label[j] = cell_label[j-1];
        end

        tkk_cell #(
            .SCORE_BITS (SCORE_BITS),
            .KW         (KW),
            .IDX        (j)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .k_eff      (k_eff),
            .filled     (filled),
            .new_score  (s_score),
            .new_label  (new_label),
            .left_ge    (left_ge[j]),
            .left_score (left_score[j]),
            .left_label (left_label[j]),
            .ge_out     (cell_ge[j]),
            .score_out  (cell_score[j]),
            .label_out  (cell_label[j]),
            .upd_score  (cell_upd_scr[j]),
            .upd_label  (cell_upd_lab[j])
        );
    end

    //------------------------------------------------------------------
    // Stage A: finished group snapshot or query; raw entry index
    //------------------------------------------------------------------
    logic [RAW_W-1:0]             raw_in;
    kind_t                        a_kind_reg;
    logic [RULE_W-1:0]            a_rule_reg;
    logic [RAW_W-1:0]             a_raw_reg;
    logic [KW-1:0]                a_n_reg;
    logic [LABEL_W-1:0]           a_lab_reg [MAX_K];
    logic signed [SCORE_BITS-1:0] a_scr_reg [MAX_K];

    assign raw_in = RAW_W'(s_superpixel) * RAW_W'(lc_eff) + RAW_W'(s_level);

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_kind_reg <= is_query ? KIND_QUERY : KIND_RANKED;
            a_rule_reg <= s_rule;
            a_raw_reg  <= raw_in;
            a_n_reg    <= is_query ? KW'(1) : n_done;
            for (int j = 0; j < MAX_K; j++) begin
                a_lab_reg[j] <= cell_upd_lab[j];
                a_scr_reg[j] <= cell_upd_scr[j];
            end
        end
    end

    //------------------------------------------------------------------
    // Stage Q: quotient of the raw index by ENTRY_COUNT
    //------------------------------------------------------------------
    logic [PRW-1:0]               a_prod;
    kind_t                        q_kind_reg;
    logic [RULE_W-1:0]            q_rule_reg;
    logic [RAW_W-1:0]             q_raw_reg;
    logic [RAW_W-1:0]             q_quo_reg;
    logic [KW-1:0]                q_n_reg;
    logic [LABEL_W-1:0]           q_lab_reg [MAX_K];
    logic signed [SCORE_BITS-1:0] q_scr_reg [MAX_K];

    assign a_prod = PRW'(a_raw_reg) * PRW'(RECIP);

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            q_kind_reg <= a_kind_reg;
            q_rule_reg <= a_rule_reg;
            q_raw_reg  <= a_raw_reg;
            q_quo_reg  <= RAW_W'(a_prod >> SHIFT);
            q_n_reg    <= a_n_reg;
            for (int j = 0; j < MAX_K; j++) begin
                q_lab_reg[j] <= a_lab_reg[j];
                q_scr_reg[j] <= a_scr_reg[j];
            end
        end
    end

    // remainder is exact, no correction step needed
    logic [PRW-1:0]   q_qe;
    logic [RAW_W-1:0] q_rem;
    logic [EW-1:0]    q_idx;

    assign q_qe  = PRW'(q_quo_reg) * PRW'(E_CONST);
    assign q_rem = q_raw_reg - RAW_W'(q_qe);
    assign q_idx = EW'(q_rem);

    //------------------------------------------------------------------
    // Stage B: stored best read, compare, write back
    //------------------------------------------------------------------
    logic signed [SUM_BITS-1:0]   b_sum;
    kind_t                        b_kind_reg;
    logic [RULE_W-1:0]            b_rule_reg;
    logic [EW-1:0]                b_idx_reg;
    logic [KW-1:0]                b_n_reg;
    logic [LABEL_W-1:0]           b_lab_reg [MAX_K];
    logic signed [SCORE_BITS-1:0] b_scr_reg [MAX_K];

    tkk_sum #(
        .SCORE_BITS (SCORE_BITS),
        .MAX_K      (MAX_K),
        .KW         (KW),
        .SUM_BITS   (SUM_BITS)
    ) u_sum (
        .aclk       (aclk),
        .adv_first  (a_adv),
        .adv_second (q_adv),
        .n          (a_n_reg),
        .scores     (a_scr_reg),
        .sum_out    (b_sum)
    );

    always_ff @(posedge aclk) begin
        if (q_adv) begin
            b_kind_reg <= q_kind_reg;
            b_rule_reg <= q_rule_reg;
            b_idx_reg  <= q_idx;
            b_n_reg    <= q_n_reg;
            for (int j = 0; j < MAX_K; j++) begin
                b_lab_reg[j] <= q_lab_reg[j];
                b_scr_reg[j] <= q_scr_reg[j];
            end
        end
    end

    // best store: {sum, rule, top label, top score} per entry
    logic [MW-1:0] best_mem [ENTRY_COUNT];
    logic [MW-1:0] rd_reg;
    logic [MW-1:0] fwd_word_reg;
    logic          fwd_reg;
    logic [MW-1:0] best_word;
    logic [MW-1:0] wr_word;
    logic          wr_en;
    logic          b_upd;

    logic signed [SUM_BITS-1:0]   best_sum;
    logic [RULE_W-1:0]            best_rule;
    logic [LABEL_W-1:0]           best_label;
    logic signed [SCORE_BITS-1:0] best_score;

    // a write leaving B on the same edge as the next item reads that entry is forwarded
    assign best_word = fwd_reg ? fwd_word_reg : rd_reg;
    assign {best_sum, best_rule, best_label, best_score} = best_word;

    assign b_upd   = (b_kind_reg == KIND_RANKED) &&
                     ((b_rule_reg == FRESH_RULE) || (b_sum > best_sum));
    assign wr_en   = b_adv && b_upd;
    assign wr_word = {b_sum, b_rule_reg, b_lab_reg[0], b_scr_reg[0]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            best_mem[b_idx_reg] <= wr_word;
        end
        if (q_adv) begin
            rd_reg       <= best_mem[q_idx];
            fwd_word_reg <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (q_adv) begin
            fwd_reg <= wr_en && (b_idx_reg == q_idx);
        end
    end

    //------------------------------------------------------------------
    // Stage C: result register, one rank per accepted transaction
    //------------------------------------------------------------------
    kind_t                        c_kind_reg;
    logic [KW-1:0]                c_n_reg;
    logic signed [SUM_BITS-1:0]   c_sum_reg;
    logic                         c_upd_reg;
    logic [RULE_W-1:0]            c_rule_reg;
    logic [RI_W-1:0]              c_rank_reg;
    logic [LABEL_W-1:0]           c_lab_reg [MAX_K];
    logic signed [SCORE_BITS-1:0] c_scr_reg [MAX_K];

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            c_kind_reg <= b_kind_reg;
            c_n_reg    <= b_n_reg;
            c_upd_reg  <= b_upd;
            c_rule_reg <= b_upd ? b_rule_reg : best_rule;
            c_sum_reg  <= (b_kind_reg == KIND_QUERY) ? best_sum : b_sum;
            for (int j = 0; j < MAX_K; j++) begin
                c_lab_reg[j] <= b_lab_reg[j];
                c_scr_reg[j] <= b_scr_reg[j];
            end
            // a query answer carries the stored top label and score in rank 0
            if (b_kind_reg == KIND_QUERY) begin
                c_lab_reg[0] <= best_label;
                c_scr_reg[0] <= best_score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_rank_reg <= '0;
        end else if (b_adv) begin
            c_rank_reg <= '0;
        end else if (m_valid && m_ready) begin
            c_rank_reg <= c_rank_reg + RI_W'(1);
        end
    end

    assign m_valid     = c_valid_reg;
    assign m_kind      = c_kind_reg;
    assign m_rank      = RANK_W'(c_rank_reg);
    assign m_label     = c_lab_reg[c_rank_reg];
    assign m_value     = c_scr_reg[c_rank_reg];
    assign m_top_sum   = c_sum_reg;
    assign m_updated   = c_upd_reg;
    assign m_best_rule = c_rule_reg;
    assign m_last      = ((KW'(c_rank_reg) + KW'(1)) == c_n_reg);

    //------------------------------------------------------------------
    // Stage valid flags
    //------------------------------------------------------------------
    assign a_valid_next = a_load || (a_valid_reg && !a_adv);
    assign q_valid_next = a_adv || (q_valid_reg && !q_adv);
    assign b_valid_next = q_adv || (b_valid_reg && !b_adv);
    assign c_valid_next = b_adv || (c_valid_reg && !(m_ready && m_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            q_valid_reg <= q_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

endmodule
